// ----- src/dhtr_pkg.sv -----
// shared types and constants for the single-wire sensor reader
// no dependencies; used by every module under src
package dhtr_pkg;

    localparam int unsigned FRAME_BYTES   = 5;
    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned HELD_BYTES    = FRAME_BYTES - 1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

    // register reset values
    localparam logic [15:0] START_LOW_RST    = 16'd25000;
    localparam logic [7:0]  RELEASE_HIGH_RST = 8'd30;
    localparam logic [7:0]  SETTLE_RST       = 8'd2;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd40;
    localparam logic [9:0]  TIMEOUT_RST      = 10'd500;

    // transaction status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_RSP_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_DATA_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_CHECKSUM     = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_DRV_LOW    = 4'd1,
        PH_DRV_HIGH   = 4'd2,
        PH_SETTLE     = 4'd3,
        PH_RSP_LOW    = 4'd4,
        PH_RSP_HIGH   = 4'd5,
        PH_RSP_END    = 4'd6,
        PH_BIT_LOW    = 4'd7,
        PH_BIT_HIGH   = 4'd8,
        PH_BIT_SAMPLE = 4'd9
    } phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  settle_ticks;
        logic [7:0]  sample_delay_ticks;
        logic [9:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       line_drive;
        logic       line_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temperature_int;
        logic [7:0] temperature_frac;
    } res_t;

endpackage

// ----- src/dht11_single_wire_reader_unit.sv -----
// single-wire humidity/temperature sensor reader, one microsecond tick per beat
// the result beat of an accepted tick is registered and offered on m_ in the next cycle
// throughput: one tick beat per cycle; s_ready drops only while a result is held and m_ready is low
// reset (aresetn, synchronous, active low): phase idle, counters clear, held values
// zero, status ok, registers to 25000/30/2/40/500 ticks, result register empty
// depends on dhtr_pkg, dhtr_cfg, dhtr_core, dhtr_out
module dht11_single_wire_reader_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dhtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dhtr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // tick input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_req,
    input  logic                                s_line_in,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_line_drive,
    output logic                                m_line_out,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [1:0]                          m_status,
    output logic [7:0]                          m_humidity_int,
    output logic [7:0]                          m_humidity_frac,
    output logic [7:0]                          m_temperature_int,
    output logic [7:0]                          m_temperature_frac
);

    dhtr_pkg::cfg_t cfg;
    dhtr_pkg::res_t step_res;
    dhtr_pkg::res_t out_res;
    logic           room;
    logic           accept;

    // a tick beat is taken whenever the result register has space
    assign s_ready = room;
    assign accept  = s_valid && room;

    // register bank; a write takes effect at the edge it is presented
    dhtr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // protocol sequencer: advances one step per accepted tick beat
    dhtr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step_en   (accept),
        .start_req (s_start_req),
        .line_in   (s_line_in),
        .res       (step_res)
    );

    // result register decouples the two channels
    dhtr_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .res_in  (step_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .room    (room),
        .res_out (out_res)
    );

    // result beat fields
    assign m_line_drive       = out_res.line_drive;
    assign m_line_out         = out_res.line_out;
    assign m_busy_res         = out_res.busy_res;
    assign m_done_res         = out_res.done_res;
    assign m_status           = out_res.status;
    assign m_humidity_int     = out_res.humidity_int;
    assign m_humidity_frac    = out_res.humidity_frac;
    assign m_temperature_int  = out_res.temperature_int;
    assign m_temperature_frac = out_res.temperature_frac;

endmodule

// ----- src/dhtr_cfg.sv -----
// configuration register bank for the sensor reader
// depends on dhtr_pkg
module dhtr_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dhtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dhtr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output dhtr_pkg::cfg_t                      cfg
);

    dhtr_pkg::cfg_t cfg_reg;
    dhtr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                dhtr_pkg::CFG_START_LOW:    cfg_next.start_low_ticks    = cfg_wr_data;
                dhtr_pkg::CFG_RELEASE_HIGH: cfg_next.release_high_ticks = cfg_wr_data[7:0];
                dhtr_pkg::CFG_SETTLE:       cfg_next.settle_ticks       = cfg_wr_data[7:0];
                dhtr_pkg::CFG_SAMPLE_DELAY: cfg_next.sample_delay_ticks = cfg_wr_data[7:0];
                dhtr_pkg::CFG_TIMEOUT:      cfg_next.timeout_ticks      = cfg_wr_data[9:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks    <= dhtr_pkg::START_LOW_RST;
            cfg_reg.release_high_ticks <= dhtr_pkg::RELEASE_HIGH_RST;
            cfg_reg.settle_ticks       <= dhtr_pkg::SETTLE_RST;
            cfg_reg.sample_delay_ticks <= dhtr_pkg::SAMPLE_DELAY_RST;
            cfg_reg.timeout_ticks      <= dhtr_pkg::TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/dhtr_core.sv -----
// per-tick protocol sequencer: state registers and next-state/result logic
// depends on dhtr_pkg
module dhtr_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  dhtr_pkg::cfg_t  cfg,
    input  logic            step_en,
    input  logic            start_req,
    input  logic            line_in,
    output dhtr_pkg::res_t  res
);

    dhtr_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      count_reg, count_next;
    logic [9:0]       budget_reg, budget_next;
    logic [2:0]       bit_reg, bit_next;
    logic [2:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       frame_reg [dhtr_pkg::HELD_BYTES];
    logic [7:0]       frame_next [dhtr_pkg::HELD_BYTES];
    logic [7:0]       held_reg [dhtr_pkg::HELD_BYTES];
    logic [7:0]       held_next [dhtr_pkg::HELD_BYTES];
    logic             done_next;

    logic [15:0] count_inc;
    logic [9:0]  budget_dec;
    logic        wait_level;
    logic        wait_met;
    logic        wait_fail;
    logic [7:0]  shift_new;
    logic [7:0]  frame_sum;

    assign count_inc  = count_reg + 16'd1;
    assign budget_dec = budget_reg - 10'd1;
    assign wait_level = (phase_reg == dhtr_pkg::PH_RSP_HIGH) ||
                        (phase_reg == dhtr_pkg::PH_BIT_HIGH);
    assign wait_met   = (budget_reg != 10'd0) && (line_in == wait_level);
    assign wait_fail  = (budget_reg == 10'd0) ||
                        ((line_in != wait_level) && (budget_dec == 10'd0));
    assign shift_new  = {shift_reg[6:0], line_in};
    assign frame_sum  = frame_reg[0] + frame_reg[1] + frame_reg[2] + frame_reg[3];

    // next state
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        budget_next = budget_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        status_next = status_reg;
        frame_next  = frame_reg;
        held_next   = held_reg;
        done_next   = 1'b0;

        unique case (phase_reg)
            dhtr_pkg::PH_IDLE: begin
                if (start_req) begin
                    phase_next = dhtr_pkg::PH_DRV_LOW;
                    count_next = 16'd1;
                end
            end
            dhtr_pkg::PH_DRV_LOW: begin
                if (count_reg >= cfg.start_low_ticks) begin
                    phase_next = dhtr_pkg::PH_DRV_HIGH;
                    count_next = 16'd1;
                end else begin
                    count_next = count_inc;
                end
            end
            dhtr_pkg::PH_DRV_HIGH: begin
                if (count_reg >= {8'd0, cfg.release_high_ticks}) begin
                    if (cfg.settle_ticks == 8'd0) begin
                        phase_next  = dhtr_pkg::PH_RSP_LOW;
                        count_next  = 16'd0;
                        budget_next = cfg.timeout_ticks;
                    end else begin
                        phase_next = dhtr_pkg::PH_SETTLE;
                        count_next = 16'd1;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            dhtr_pkg::PH_SETTLE: begin
                if (count_reg >= {8'd0, cfg.settle_ticks}) begin
                    phase_next  = dhtr_pkg::PH_RSP_LOW;
                    count_next  = 16'd0;
                    budget_next = cfg.timeout_ticks;
                end else begin
                    count_next = count_inc;
                end
            end
            dhtr_pkg::PH_RSP_LOW, dhtr_pkg::PH_RSP_HIGH, dhtr_pkg::PH_RSP_END: begin
                if ((budget_reg != 10'd0) && (line_in != wait_level)) begin
                    budget_next = budget_dec;
                end
                if (wait_fail) begin
                    phase_next  = dhtr_pkg::PH_IDLE;
                    count_next  = 16'd0;
                    status_next = dhtr_pkg::ST_RSP_TIMEOUT;
                    done_next   = 1'b1;
                end else if (wait_met) begin
                    if (phase_reg == dhtr_pkg::PH_RSP_END) begin
                        // response complete, first data byte begins
                        byte_next   = 3'd0;
                        phase_next  = dhtr_pkg::PH_BIT_LOW;
                        bit_next    = 3'd0;
                        shift_next  = 8'd0;
                        budget_next = cfg.timeout_ticks;
                    end else if (phase_reg == dhtr_pkg::PH_RSP_LOW) begin
                        phase_next = dhtr_pkg::PH_RSP_HIGH;
                    end else begin
                        phase_next = dhtr_pkg::PH_RSP_END;
                    end
                end
            end
            dhtr_pkg::PH_BIT_LOW, dhtr_pkg::PH_BIT_HIGH: begin
                if ((budget_reg != 10'd0) && (line_in != wait_level)) begin
                    budget_next = budget_dec;
                end
                if (wait_fail) begin
                    phase_next  = dhtr_pkg::PH_IDLE;
                    count_next  = 16'd0;
                    status_next = dhtr_pkg::ST_DATA_TIMEOUT;
                    done_next   = 1'b1;
                end else if (wait_met) begin
                    if (phase_reg == dhtr_pkg::PH_BIT_HIGH) begin
                        phase_next = dhtr_pkg::PH_BIT_SAMPLE;
                        count_next = 16'd0;
                    end else begin
                        phase_next = dhtr_pkg::PH_BIT_HIGH;
                    end
                end
            end
            dhtr_pkg::PH_BIT_SAMPLE: begin
                count_next = count_inc;
                if (count_inc >= {8'd0, cfg.sample_delay_ticks}) begin
                    shift_next = shift_new;
                    if (bit_reg != 3'(dhtr_pkg::BITS_PER_BYTE - 1)) begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = dhtr_pkg::PH_BIT_LOW;
                    end else begin
                        bit_next = 3'd0;
                        if (byte_reg < 3'(dhtr_pkg::FRAME_BYTES - 1)) begin
                            frame_next[byte_reg[1:0]] = shift_new;
                            byte_next   = byte_reg + 3'd1;
                            phase_next  = dhtr_pkg::PH_BIT_LOW;
                            shift_next  = 8'd0;
                            budget_next = cfg.timeout_ticks;
                        end else begin
                            // checksum byte: compare against sum of the first four
                            phase_next = dhtr_pkg::PH_IDLE;
                            count_next = 16'd0;
                            done_next  = 1'b1;
                            if (frame_sum == shift_new) begin
                                held_next   = frame_reg;
                                status_next = dhtr_pkg::ST_OK;
                            end else begin
                                status_next = dhtr_pkg::ST_CHECKSUM;
                            end
                        end
                    end
                end
            end
            default: begin
                phase_next = dhtr_pkg::PH_IDLE;
                count_next = 16'd0;
            end
        endcase
    end

    // result for this tick, taken from the post-step state
    always_comb begin
        res.line_drive       = (phase_next == dhtr_pkg::PH_IDLE) ||
                               (phase_next == dhtr_pkg::PH_DRV_HIGH) ||
                               (phase_next == dhtr_pkg::PH_DRV_LOW);
        res.line_out         = (phase_next == dhtr_pkg::PH_IDLE) ||
                               (phase_next == dhtr_pkg::PH_DRV_HIGH);
        res.busy_res         = (phase_next != dhtr_pkg::PH_IDLE);
        res.done_res         = done_next;
        res.status           = status_next;
        res.humidity_int     = held_next[0];
        res.humidity_frac    = held_next[1];
        res.temperature_int  = held_next[2];
        res.temperature_frac = held_next[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dhtr_pkg::PH_IDLE;
            count_reg  <= 16'd0;
            budget_reg <= 10'd0;
            bit_reg    <= 3'd0;
            byte_reg   <= 3'd0;
            shift_reg  <= 8'd0;
            status_reg <= dhtr_pkg::ST_OK;
            held_reg   <= '{default: 8'd0};
        end else if (step_en) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            budget_reg <= budget_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            shift_reg  <= shift_next;
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

    // frame bytes are always written before they are read
    always_ff @(posedge aclk) begin
        if (step_en) begin
            frame_reg <= frame_next;
        end
    end

endmodule

// ----- src/dhtr_out.sv -----
// result register between the sequencer and the result channel
// depends on dhtr_pkg
module dhtr_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  dhtr_pkg::res_t  res_in,
    input  logic            m_ready,
    output logic            m_valid,
    output logic            room,
    output dhtr_pkg::res_t  res_out
);

    logic           valid_reg, valid_next;
    dhtr_pkg::res_t res_reg;

    // free when empty or when the held beat leaves this cycle
    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule
